// ===== rtl/core/msa_mcs_pkg.sv =====
// Package: constants, register codes, payload and control types of the segmenter.
package msa_mcs_pkg;

    localparam int ROWS        = 8;
    localparam int SYM_W       = 8;
    localparam int MAX_LEN     = 32;
    localparam int MAX_COLUMNS = 65536;
    localparam int POS_W       = 17;
    localparam int BACK_W      = 16;
    localparam int COST_W      = 20;
    localparam int ADDR_W      = $clog2(MAX_LEN);
    localparam int LEN_W       = $clog2(MAX_LEN + 1);
    localparam int ROW_CNT_W   = 4;
    localparam int CNT_W       = $clog2(ROWS + 1);
    localparam int STR_W       = SYM_W * MAX_LEN;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [SYM_W-1:0]  GAP_SYMBOL = 8'h2D;
    localparam logic [COST_W-1:0] COST_SAT   = {COST_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 3'd0,
        CFG_MIN_LEN   = 3'd1,
        CFG_MAX_LEN   = 3'd2,
        CFG_GAPS      = 3'd3,
        CFG_PERFECT   = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [ROWS*SYM_W-1:0] column_symbols;
        logic                  first_column;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  column_index;
        logic [COST_W-1:0] best_cost;
        logic [BACK_W-1:0] back_index;
        logic              reachable;
    } out_word_t;

    typedef struct packed {
        logic                 clear;
        logic                 shift;
        logic                 gaps_keep;
        logic [ROW_CNT_W-1:0] rows_used;
    } str_ctrl_t;

endpackage

// ===== rtl/core/msa_mcs_strings.sv =====
// Row string unit: prepends columns to per-row strings and counts distinct rows.
module msa_mcs_strings (
    input  logic                                      aclk,
    input  msa_mcs_pkg::str_ctrl_t                    ctrl,
    input  logic [msa_mcs_pkg::ROWS*msa_mcs_pkg::SYM_W-1:0] column,
    output logic [msa_mcs_pkg::CNT_W-1:0]             distinct
);

    logic [msa_mcs_pkg::STR_W-1:0] str_reg [msa_mcs_pkg::ROWS];
    logic [msa_mcs_pkg::LEN_W-1:0] len_reg [msa_mcs_pkg::ROWS];
    logic [msa_mcs_pkg::ROWS-1:0]  eq_reg  [msa_mcs_pkg::ROWS];
    logic [msa_mcs_pkg::ROWS-1:0]  eq_next [msa_mcs_pkg::ROWS];

    always_ff @(posedge aclk) begin
        for (int r = 0; r < msa_mcs_pkg::ROWS; r++) begin
            if (ctrl.clear) begin
                str_reg[r] <= '0;
                len_reg[r] <= '0;
            end else if (ctrl.shift && (ctrl.gaps_keep ||
                         column[r*msa_mcs_pkg::SYM_W +: msa_mcs_pkg::SYM_W]
                         != msa_mcs_pkg::GAP_SYMBOL)) begin
                str_reg[r] <= {str_reg[r][msa_mcs_pkg::STR_W-msa_mcs_pkg::SYM_W-1:0],
                               column[r*msa_mcs_pkg::SYM_W +: msa_mcs_pkg::SYM_W]};
                len_reg[r] <= len_reg[r] + 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < msa_mcs_pkg::ROWS; i++) begin
            for (int j = 0; j < msa_mcs_pkg::ROWS; j++) begin
                eq_next[i][j] = (j < i) && (len_reg[i] == len_reg[j]) &&
                                (str_reg[i] == str_reg[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < msa_mcs_pkg::ROWS; i++) begin
            eq_reg[i] <= eq_next[i];
        end
    end

    always_comb begin
        distinct = '0;
        for (int i = 0; i < msa_mcs_pkg::ROWS; i++) begin
            if ((i < int'(ctrl.rows_used)) && !(|eq_reg[i])) begin
                distinct = distinct + 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/msa_min_cardinality_segmenter.sv =====
// Top level: minimum-cardinality segmentation cost, one alignment column per word.
//
// channel | direction | handshake              | word
// s_      | in        | s_valid / s_ready      | in_word_t (column_symbols, first_column)
// m_      | out       | m_valid / m_ready      | out_word_t (index, cost, back, reachable)
// cfg_    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// With L = min(max_len clamped to MAX_LEN, column index), a column passes from accept
// to accept through L passes of the shared row string unit, a pipe drain, a final
// step and a return to idle; with L = 0 there are no passes.
// s_ready is high only while idle. A result waits in the output register; the
// final step holds while that register is still full.
// Reset is synchronous; window and cost memories need no clearing.
module msa_min_cardinality_segmenter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  msa_mcs_pkg::in_word_t                  s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output msa_mcs_pkg::out_word_t                 m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [msa_mcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [msa_mcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int W  = msa_mcs_pkg::ROWS * msa_mcs_pkg::SYM_W;
    localparam int PW = msa_mcs_pkg::POS_W;
    localparam int CW = msa_mcs_pkg::COST_W;
    localparam int LW = msa_mcs_pkg::LEN_W;
    localparam int AW = msa_mcs_pkg::ADDR_W;
    localparam int BW = msa_mcs_pkg::BACK_W;

    // configuration
    logic [msa_mcs_pkg::ROW_CNT_W-1:0] row_count_reg;
    logic [5:0] min_len_reg, max_len_reg;
    logic gaps_reg, perfect_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= 4'd8;
            min_len_reg   <= 6'd1;
            max_len_reg   <= 6'd31;
            gaps_reg      <= 1'b0;
            perfect_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msa_mcs_pkg::CFG_ROW_COUNT: row_count_reg <= cfg_data[3:0];
                msa_mcs_pkg::CFG_MIN_LEN:   min_len_reg   <= cfg_data[5:0];
                msa_mcs_pkg::CFG_MAX_LEN:   max_len_reg   <= cfg_data[5:0];
                msa_mcs_pkg::CFG_GAPS:      gaps_reg      <= cfg_data[0];
                msa_mcs_pkg::CFG_PERFECT:   perfect_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [msa_mcs_pkg::ROW_CNT_W-1:0] rows_used;
    logic [LW-1:0] lo, hi;

    always_comb begin
        if (row_count_reg == '0) rows_used = 4'd1;
        else if (row_count_reg > 4'(msa_mcs_pkg::ROWS)) rows_used = 4'(msa_mcs_pkg::ROWS);
        else rows_used = row_count_reg;
        lo = (min_len_reg == '0) ? LW'(1) : LW'(min_len_reg);
        hi = (max_len_reg > 6'(msa_mcs_pkg::MAX_LEN)) ? LW'(msa_mcs_pkg::MAX_LEN)
                                                      : LW'(max_len_reg);
    end

    // sequencer state
    msa_mcs_pkg::state_t state_reg, state_next;
    logic [PW-1:0] pos_reg, y_reg;
    logic [LW-1:0] k_reg, kmax_reg;
    logic [W-1:0]  col_reg;
    logic [CW-1:0] pbc_reg, best_reg;
    logic          pbc_none_reg, best_none_reg;
    logic [PW-1:0] pbb_reg;
    logic [BW-1:0] back_reg;

    logic s_acc, newstart, final_go;
    logic [PW-1:0] y_acc, x_run;
    logic [LW-1:0] kmax_acc;

    assign s_ready  = (state_reg == msa_mcs_pkg::ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign newstart = s_data.first_column || (pos_reg >= PW'(msa_mcs_pkg::MAX_COLUMNS));
    assign y_acc    = (newstart ? '0 : pos_reg) + 1'b1;
    assign kmax_acc = (y_acc >= PW'(hi)) ? hi : y_acc[LW-1:0];
    assign x_run    = y_reg - PW'(k_reg);
    assign final_go = (state_reg == msa_mcs_pkg::ST_FINAL) && (!m_valid || m_ready);

    // memories
    logic [W-1:0]  win_mem  [msa_mcs_pkg::MAX_LEN];
    logic [CW:0]   cost_mem [msa_mcs_pkg::MAX_LEN];
    logic [W-1:0]  win_rdata;
    logic [CW:0]   cost_rdata;
    logic [AW-1:0] win_raddr, cost_raddr;
    logic [PW-1:0] win_pos;

    assign win_pos    = x_run + 1'b1;
    assign win_raddr  = win_pos[AW-1:0];
    assign cost_raddr = x_run[AW-1:0];

    // final step values
    logic perf;
    logic [CW-1:0] fb, pcand;
    logic          fnone;
    logic [BW-1:0] fback;
    logic [CW:0]   psum;

    always_comb begin
        perf = 1'b1;
        for (int r = 1; r < msa_mcs_pkg::ROWS; r++) begin
            if ((r < int'(rows_used)) &&
                (col_reg[r*msa_mcs_pkg::SYM_W +: msa_mcs_pkg::SYM_W] !=
                 col_reg[msa_mcs_pkg::SYM_W-1:0])) begin
                perf = 1'b0;
            end
        end
        psum  = {1'b0, pbc_reg} + 1'b1;
        pcand = psum[CW] ? msa_mcs_pkg::COST_SAT : psum[CW-1:0];
        fb    = best_reg;
        fnone = best_none_reg;
        fback = back_reg;
        if (perfect_reg && perf && !pbc_none_reg && (best_none_reg || pcand <= best_reg)) begin
            fb    = pcand;
            fnone = 1'b0;
            fback = pbb_reg[BW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) win_mem[y_acc[AW-1:0]] <= s_data.column_symbols;
        if (final_go) cost_mem[y_reg[AW-1:0]] <= {fnone, fb};
        win_rdata  <= win_mem[win_raddr];
        cost_rdata <= cost_mem[cost_raddr];
    end

    // pipeline: S1 memory data, S2 strings ready, S3 count and compare
    logic          p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic          p1_eval_reg, p2_eval_reg, p3_eval_reg;
    logic          p1_xzero_reg;
    logic [BW-1:0] p1_x_reg, p2_x_reg, p3_x_reg;
    logic          p2_cnone_reg, p3_cnone_reg;
    logic [CW-1:0] p2_c_reg, p3_c_reg;
    logic          running;

    assign running = (state_reg == msa_mcs_pkg::ST_RUN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= running;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
        p1_eval_reg  <= (k_reg >= lo);
        p1_xzero_reg <= (x_run == '0);
        p1_x_reg     <= x_run[BW-1:0];
        p2_eval_reg  <= p1_eval_reg;
        p2_x_reg     <= p1_x_reg;
        p2_cnone_reg <= p1_xzero_reg ? 1'b0 : cost_rdata[CW];
        p2_c_reg     <= p1_xzero_reg ? '0 : cost_rdata[CW-1:0];
        p3_eval_reg  <= p2_eval_reg;
        p3_x_reg     <= p2_x_reg;
        p3_cnone_reg <= p2_cnone_reg;
        p3_c_reg     <= p2_c_reg;
    end

    msa_mcs_pkg::str_ctrl_t str_ctrl;
    logic [msa_mcs_pkg::CNT_W-1:0] distinct;

    assign str_ctrl.clear     = s_acc;
    assign str_ctrl.shift     = p1_valid_reg;
    assign str_ctrl.gaps_keep = gaps_reg;
    assign str_ctrl.rows_used = rows_used;

    msa_mcs_strings u_strings (
        .aclk     (aclk),
        .ctrl     (str_ctrl),
        .column   (win_rdata),
        .distinct (distinct)
    );

    logic [CW:0]   csum;
    logic [CW-1:0] cand;
    logic          take;

    assign csum = {1'b0, p3_c_reg} + (CW+1)'(distinct);
    assign cand = csum[CW] ? msa_mcs_pkg::COST_SAT : csum[CW-1:0];
    assign take = p3_valid_reg && p3_eval_reg && !p3_cnone_reg &&
                  (best_none_reg || cand < best_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msa_mcs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msa_mcs_pkg::ST_IDLE: begin
                if (s_acc) state_next = (kmax_acc == '0) ? msa_mcs_pkg::ST_DRAIN
                                                         : msa_mcs_pkg::ST_RUN;
            end
            msa_mcs_pkg::ST_RUN: begin
                if (k_reg == kmax_reg) state_next = msa_mcs_pkg::ST_DRAIN;
            end
            msa_mcs_pkg::ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg)
                    state_next = msa_mcs_pkg::ST_FINAL;
            end
            msa_mcs_pkg::ST_FINAL: begin
                if (final_go) state_next = msa_mcs_pkg::ST_IDLE;
            end
            default: state_next = msa_mcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            pbc_reg      <= '0;
            pbc_none_reg <= 1'b0;
            pbb_reg      <= '0;
            m_valid      <= 1'b0;
        end else begin
            if (m_valid && m_ready) m_valid <= 1'b0;
            if (s_acc && newstart) begin
                pos_reg      <= '0;
                pbc_reg      <= '0;
                pbc_none_reg <= 1'b0;
                pbb_reg      <= '0;
            end
            if (final_go) begin
                pos_reg <= y_reg;
                m_valid <= 1'b1;
                if (perf) begin
                    if (!fnone && (pbc_none_reg || fb < pbc_reg)) begin
                        pbc_reg      <= fb;
                        pbc_none_reg <= 1'b0;
                        pbb_reg      <= y_reg;
                    end
                end else begin
                    pbc_reg      <= fb;
                    pbc_none_reg <= fnone;
                    pbb_reg      <= y_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            y_reg         <= y_acc;
            col_reg       <= s_data.column_symbols;
            k_reg         <= LW'(1);
            kmax_reg      <= kmax_acc;
            best_none_reg <= 1'b1;
            best_reg      <= '0;
            back_reg      <= '0;
        end else begin
            if (running) k_reg <= k_reg + 1'b1;
            if (take) begin
                best_none_reg <= 1'b0;
                best_reg      <= cand;
                back_reg      <= p3_x_reg;
            end
        end
        if (final_go) begin
            m_data.column_index <= y_reg;
            m_data.best_cost    <= fnone ? '0 : fb;
            m_data.back_index   <= fnone ? '0 : fback;
            m_data.reachable    <= !fnone;
        end
    end

    ap_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msa_mcs_pkg::ST_IDLE) |-> (!p1_valid_reg && !p2_valid_reg && !p3_valid_reg))
        else $error("pipeline busy while idle");

    ap_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        running |-> (k_reg <= kmax_reg && k_reg >= LW'(1)))
        else $error("segment length out of range");

    ap_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.reachable) |-> (m_data.best_cost == '0 && m_data.back_index == '0))
        else $error("unreachable result carries cost");

    ap_final_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == msa_mcs_pkg::ST_FINAL && m_valid && !m_ready) |=>
        (state_reg == msa_mcs_pkg::ST_FINAL))
        else $error("final step overwrote pending result");

endmodule
